// ----- hw/rtl/bseq_pkg.sv -----
// Shared types and codes for the bounded sorted event queue.
package bseq_pkg;

	typedef enum logic [0:0] {
		CMD_INSERT = 1'b0,
		CMD_DELETE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_LEFT,
		CELL_RIGHT
	} cell_op_t;

	typedef struct packed {
		cmd_t               command;
		logic [31:0]        event_time;
		logic [7:0]         sensor;
		logic signed [15:0] sample_value;
	} req_t;

	typedef struct packed {
		logic       ok;
		logic [4:0] length;
	} rsp_t;

	typedef struct packed {
		logic [31:0]        key;
		logic [7:0]         id;
		logic signed [15:0] value;
	} entry_t;

	typedef struct packed {
		logic   go;
		cmd_t   command;
		logic   full;
		entry_t item;
	} cell_ctl_t;

endpackage

// ----- hw/rtl/bseq_cell.sv -----
// One slot of the sorted table: holds an entry, compares it and shifts with its neighbors.
module bseq_cell import bseq_pkg::*; (
	input  logic      clk,
	input  logic      occupied,
	input  cell_ctl_t ctl,
	input  entry_t    left_entry,
	input  entry_t    right_entry,
	input  logic      lt_left,
	input  logic      lt_right,
	input  logic      hit_in,
	output entry_t    entry,
	output logic      lt,
	output logic      hit_out
);

	entry_t   entry_q;
	logic     match;
	cell_op_t op;

	assign entry   = entry_q;
	assign lt      = occupied && (entry_q.key < ctl.item.key);
	assign match   = occupied && (entry_q.id == ctl.item.id);
	assign hit_out = hit_in | match;

	always_comb begin
		op = CELL_HOLD;
		if (ctl.go) begin
			case (ctl.command)
				CMD_INSERT: begin
					if (ctl.full) begin
						if (lt_right) begin
							op = CELL_RIGHT;
						end else if (lt) begin
							op = CELL_LOAD;
						end
					end else begin
						if (lt) begin
							op = CELL_HOLD;
						end else if (lt_left) begin
							op = CELL_LOAD;
						end else begin
							op = CELL_LEFT;
						end
					end
				end
				CMD_DELETE: begin
					if (hit_in || match) begin
						op = CELL_RIGHT;
					end
				end
				default: op = CELL_HOLD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			CELL_LOAD:  entry_q <= ctl.item;
			CELL_LEFT:  entry_q <= left_entry;
			CELL_RIGHT: entry_q <= right_entry;
			default:    entry_q <= entry_q;
		endcase
	end

endmodule

// ----- hw/rtl/bounded_sorted_event_queue.sv -----
// Top level of the bounded sorted event queue: command register, count and the row of cells.
//
// The queue takes no new command while busy is high: the edge that accepts start latches the
// command and raises busy, and on the next edge every cell compares its entry with the command
// and shifts in parallel, so the row of cells sets the pace whatever the fill level. done is a
// one-cycle strobe raised by that edge, with ok and the new length; the receiver cannot hold it
// off, so it must take the result then. No clearing pass follows reset: entries beyond the count
// are never looked at. Capacity may be written only while busy is low and no result is pending.
module bounded_sorted_event_queue import bseq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  req_t       request,
	output logic       done,
	output rsp_t       result,
	input  logic       cfg_we,
	input  logic [4:0] cfg_data
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = CW + 5;

	logic          valid_s1;
	req_t          req_s1;
	logic [CW-1:0] count_q;
	logic [4:0]    cap_q;
	logic          done_q;
	rsp_t          result_q;

	entry_t        entries [DEPTH];
	logic          lts     [DEPTH];
	logic          hits    [DEPTH+1];
	cell_ctl_t     ctl;

	logic [XW-1:0] cnt_x;
	logic [XW-1:0] cap_x;
	logic [XW-1:0] cap_eff;
	logic          full;
	logic          any_hit;
	logic [XW-1:0] cnt_next;

	assign busy   = valid_s1;
	assign done   = done_q;
	assign result = result_q;

	assign cnt_x   = XW'(count_q);
	assign cap_x   = XW'(cap_q);
	assign cap_eff = (cap_x < XW'(DEPTH)) ? cap_x : XW'(DEPTH);
	assign full    = (cnt_x >= cap_eff);
	assign any_hit = hits[DEPTH];

	assign ctl.go         = valid_s1;
	assign ctl.command    = req_s1.command;
	assign ctl.full       = full;
	assign ctl.item.key   = req_s1.event_time;
	assign ctl.item.id    = req_s1.sensor;
	assign ctl.item.value = req_s1.sample_value;

	assign hits[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t left_e;
		entry_t right_e;
		logic   lt_l;
		logic   lt_r;

		if (i == 0) begin : g_first
			assign left_e = entries[i];
			assign lt_l   = 1'b1;
		end else begin : g_mid_l
			assign left_e = entries[i-1];
			assign lt_l   = lts[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_e = entries[i];
			assign lt_r    = 1'b0;
		end else begin : g_mid_r
			assign right_e = entries[i+1];
			assign lt_r    = lts[i+1];
		end

		bseq_cell u_cell (
			.clk        (clk),
			.occupied   (XW'(i) < cnt_x),
			.ctl        (ctl),
			.left_entry (left_e),
			.right_entry(right_e),
			.lt_left    (lt_l),
			.lt_right   (lt_r),
			.hit_in     (hits[i]),
			.entry      (entries[i]),
			.lt         (lts[i]),
			.hit_out    (hits[i+1])
		);
	end

	always_comb begin
		cnt_next = cnt_x;
		case (req_s1.command)
			CMD_INSERT: begin
				if (!full) begin
					cnt_next = cnt_x + XW'(1);
				end
			end
			CMD_DELETE: begin
				if (any_hit) begin
					cnt_next = cnt_x - XW'(1);
				end
			end
			default: cnt_next = cnt_x;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			count_q  <= '0;
			cap_q    <= 5'd16;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= start && !valid_s1;
			done_q   <= valid_s1;
			if (valid_s1) begin
				count_q <= cnt_next[CW-1:0];
			end
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !valid_s1) begin
			req_s1 <= request;
		end
		if (valid_s1) begin
			result_q.ok     <= (req_s1.command == CMD_INSERT) || any_hit;
			result_q.length <= cnt_next[4:0];
		end
	end

endmodule

// ----- hw/rtl/bseq_checker.sv -----
// Port-level timing checks for the bounded sorted event queue, bound to the top level.
module bseq_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("Accepted command did not raise busy.");

	a_busy_one: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("Busy lasted more than one cycle.");

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("Result beat missing after work cycle.");

	a_no_stray: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |=> !done)
		else $error("Result beat without a command.");

endmodule

bind bounded_sorted_event_queue bseq_checker u_bseq_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done)
);

// ----- sim/tb_bounded_sorted_event_queue.sv -----
// Self-checking testbench for the bounded sorted event queue with a tracked event table.
`timescale 1ns / 1ps

import bseq_pkg::*;

class event_table_tracker #(int SLOTS = 16);
	logic [31:0]        key_q[SLOTS];
	logic [7:0]         id_q[SLOTS];
	logic signed [15:0] val_q[SLOTS];
	int unsigned        fill;
	logic [4:0]         capacity;
	rsp_t               awaited_status[$];
	int unsigned        mismatches;
	int unsigned        checked;
	int unsigned        inserts;
	int unsigned        drops;
	int unsigned        deletes;
	int unsigned        misses;

	function new();
		fill = 0;
		capacity = 5'd16;
		mismatches = 0;
		checked = 0;
		inserts = 0;
		drops = 0;
		deletes = 0;
		misses = 0;
	endfunction

	function void set_capacity(logic [4:0] value);
		capacity = value;
	endfunction

	function void move_slot(int unsigned dst, int unsigned src);
		key_q[dst] = key_q[src];
		id_q[dst] = id_q[src];
		val_q[dst] = val_q[src];
	endfunction

	function void note_command(req_t cmd);
		rsp_t        status;
		int unsigned room;
		int unsigned pos;
		int unsigned i;
		status.ok = 1'b1;
		pos = 0;
		if (cmd.command == CMD_INSERT) begin
			inserts++;
			room = (capacity < SLOTS) ? capacity : SLOTS;
			while (pos < fill && key_q[pos] < cmd.event_time)
				pos++;
			if (fill + 1 > room) begin
				drops++;
				if (pos != 0) begin
					for (i = 0; i + 1 < pos; i++)
						move_slot(i, i + 1);
					key_q[pos - 1] = cmd.event_time;
					id_q[pos - 1] = cmd.sensor;
					val_q[pos - 1] = cmd.sample_value;
				end
			end else begin
				for (i = fill; i > pos; i--)
					move_slot(i, i - 1);
				key_q[pos] = cmd.event_time;
				id_q[pos] = cmd.sensor;
				val_q[pos] = cmd.sample_value;
				fill++;
			end
		end else begin
			deletes++;
			while (pos < fill && id_q[pos] != cmd.sensor)
				pos++;
			if (pos >= fill) begin
				status.ok = 1'b0;
				misses++;
			end else begin
				for (i = pos; i + 1 < fill; i++)
					move_slot(i, i + 1);
				fill--;
			end
		end
		status.length = 5'(fill);
		awaited_status.push_back(status);
	endfunction

	function void report(string what, rsp_t want, rsp_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected ok=%0b length=%0d, got ok=%0b length=%0d",
				$time, what, want.ok, want.length, got.ok, got.length);
	endfunction

	function void check_status(rsp_t got);
		rsp_t want;
		checked++;
		if (awaited_status.size() == 0) begin
			want = '0;
			report("result with nothing outstanding", want, got);
		end else begin
			want = awaited_status.pop_front();
			if (got.ok !== want.ok)
				report("ok mismatch", want, got);
			else if (got.length !== want.length)
				report("length mismatch", want, got);
		end
	endfunction
endclass

module tb_bounded_sorted_event_queue;
	localparam int DEPTH = 16;
	localparam int IDLE_LIMIT = 1000;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	req_t       request;
	logic       done;
	rsp_t       result;
	logic       cfg_we;
	logic [4:0] cfg_data;

	event_table_tracker #(DEPTH) tracker;
	int unsigned idle_cycles;
	int unsigned settings_used;

	bounded_sorted_event_queue #(.DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				tracker.check_status(result);
			if (start && !busy)
				tracker.note_command(request);
			if ((start && !busy) || done)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL bounded_sorted_event_queue");
				$finish;
			end
		end
	end

	function automatic req_t make_cmd(cmd_t c, logic [31:0] t, logic [7:0] s, logic [15:0] v);
		req_t r;
		r.command = c;
		r.event_time = t;
		r.sensor = s;
		r.sample_value = v;
		return r;
	endfunction

	function automatic req_t random_cmd(int unsigned delete_pct);
		req_t        r;
		int unsigned pick;
		r.command = ($urandom_range(0, 99) < delete_pct) ? CMD_DELETE : CMD_INSERT;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			r.event_time = $urandom_range(0, 31);
		else if (pick < 70)
			r.event_time = $urandom;
		else if (pick < 80)
			r.event_time = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
		else
			r.event_time = 32'hFFFF_FFFF - $urandom_range(0, 7);
		pick = $urandom_range(0, 99);
		if (pick < 80)
			r.sensor = 8'($urandom_range(0, 7));
		else if (pick < 90)
			r.sensor = $urandom_range(0, 1) ? 8'hFF : 8'h00;
		else
			r.sensor = 8'($urandom);
		r.sample_value = 16'($urandom);
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		else if (pick < 85)
			return $urandom_range(1, 3);
		else if (pick < 97)
			return $urandom_range(4, 8);
		return $urandom_range(20, 40);
	endfunction

	task automatic issue_command(input req_t cmd);
		start <= 1'b1;
		request <= cmd;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic idle_gap(input int unsigned cycles);
		if (cycles != 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		while (tracker.awaited_status.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [4:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tracker.set_capacity(value);
		settings_used++;
	endtask

	task automatic run_random_phase(input logic [4:0] cap, input int unsigned beats,
			input int unsigned delete_pct, input bit burst_first);
		int unsigned n;
		write_capacity(cap);
		for (n = 0; n < beats; n++) begin
			issue_command(random_cmd(delete_pct));
			idle_gap((burst_first && n < 40) ? 0 : pick_gap());
		end
	endtask

	initial begin
		tracker = new();
		idle_cycles = 0;
		settings_used = 0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_capacity(5'd16);
		issue_command(make_cmd(CMD_DELETE, 32'd0, 8'd0, 16'h0000));
		issue_command(make_cmd(CMD_INSERT, 32'd100, 8'd1, 16'h0000));
		issue_command(make_cmd(CMD_INSERT, 32'd100, 8'd2, 16'h8000));
		issue_command(make_cmd(CMD_INSERT, 32'd0, 8'd0, 16'h7FFF));
		issue_command(make_cmd(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF));
		issue_command(make_cmd(CMD_INSERT, 32'd50, 8'd3, 16'h0001));
		issue_command(make_cmd(CMD_INSERT, 32'd100, 8'd1, 16'h0005));
		issue_command(make_cmd(CMD_DELETE, 32'hFFFF_FFFF, 8'd9, 16'hFFFF));
		issue_command(make_cmd(CMD_DELETE, 32'd0, 8'd1, 16'h0000));
		issue_command(make_cmd(CMD_DELETE, 32'd0, 8'hFF, 16'h0000));

		write_capacity(5'd3);
		issue_command(make_cmd(CMD_INSERT, 32'd200, 8'd7, 16'h1234));
		issue_command(make_cmd(CMD_INSERT, 32'd0, 8'd8, 16'h8001));
		issue_command(make_cmd(CMD_INSERT, 32'hFFFF_FFFF, 8'd6, 16'h7FFE));
		issue_command(make_cmd(CMD_DELETE, 32'd0, 8'd7, 16'h0000));

		write_capacity(5'd0);
		issue_command(make_cmd(CMD_INSERT, 32'd300, 8'd4, 16'h0064));
		issue_command(make_cmd(CMD_DELETE, 32'd0, 8'd6, 16'h0000));
		issue_command(make_cmd(CMD_DELETE, 32'd0, 8'hC8, 16'h0000));

		run_random_phase(5'd31, 210, 30, 1'b1);
		run_random_phase(5'd16, 210, 40, 1'b0);
		run_random_phase(5'd1, 200, 40, 1'b1);
		run_random_phase(5'd2, 200, 40, 1'b0);
		run_random_phase(5'd5, 200, 35, 1'b1);
		run_random_phase(5'd0, 100, 40, 1'b0);
		run_random_phase(5'd12, 200, 35, 1'b0);
		run_random_phase(5'(($urandom_range(0, 31))), 160, 40, 1'b1);
		run_random_phase(5'd16, 200, 35, 1'b0);

		drain();
		$display("Ran %0d inserts (%0d hit the capacity) and %0d deletes (%0d found nothing)",
			tracker.inserts, tracker.drops, tracker.deletes, tracker.misses);
		$display("over %0d capacity settings; %0d results checked, %0d mismatches",
			settings_used, tracker.checked, tracker.mismatches);
		if (tracker.mismatches == 0 && tracker.awaited_status.size() == 0)
			$display("PASS bounded_sorted_event_queue");
		else
			$display("FAIL bounded_sorted_event_queue");
		$finish;
	end
endmodule
